// ----- hdl/rexs_pkg.sv -----
// Package for the record exchange sorter: field widths, parameter defaults,
// the record and result beat types and the controller state encoding.
// No dependencies.
package rexs_pkg;

  localparam int KEY_W              = 6;
  localparam int ID_W               = 16;
  localparam int TDATA_W            = 24;
  localparam int MAX_RECORDS_DEF    = 64;
  localparam int TITLE_CAPACITY_DEF = 50;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } rec_t;

  // One result as handed from the controller to the output register
  typedef struct packed {
    rec_t rec;
    logic last;
    logic dropped;
  } beat_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_I,
    ST_SORT_H,
    ST_SORT_J,
    ST_SORT_W,
    ST_OUT_RD,
    ST_OUT
  } state_t;

endpackage

// ----- hdl/rexs_mem.sv -----
// Record store: one write port, one read port, registered read data.
// Depends on rexs_pkg.
module rexs_mem #(
  parameter int DEPTH = rexs_pkg::MAX_RECORDS_DEF,
  parameter int AW    = $clog2(rexs_pkg::MAX_RECORDS_DEF)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  rexs_pkg::rec_t wdata,
  input  logic [AW-1:0]  raddr,
  output rexs_pkg::rec_t rdata
);
  import rexs_pkg::*;

  rec_t mem_r [DEPTH];
  rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/rexs_ctrl.sv -----
// Load / exchange-sort / unload sequencer working on the record store.
// Depends on rexs_pkg and rexs_mem.
module rexs_ctrl #(
  parameter int MAX_RECORDS    = rexs_pkg::MAX_RECORDS_DEF,
  parameter int TITLE_CAPACITY = rexs_pkg::TITLE_CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rexs_pkg::KEY_W-1:0]  in_key,
  input  logic [rexs_pkg::ID_W-1:0]   in_id,
  input  logic                        in_last,
  input  logic                        out_free,
  output logic                        beat_load,
  output rexs_pkg::beat_t             beat
);
  import rexs_pkg::*;

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam logic [8:0] KEY_TOP = 9'(TITLE_CAPACITY - 1);

  state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic          overflow_r, overflow_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] o_r, o_nxt;
  rec_t          held_r, held_nxt;

  logic          we;
  logic [AW-1:0] waddr;
  rec_t          wdata;
  logic [AW-1:0] raddr;
  rec_t          rdata;

  logic          accept;
  logic          full;
  logic [CW-1:0] count_after;
  logic [AW-1:0] last_idx;
  logic          swap;
  logic          more_passes;
  logic          out_go;
  rec_t          in_rec;

  rexs_mem #(.DEPTH(MAX_RECORDS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign accept      = in_valid && (state_r == ST_LOAD);
  assign full        = (count_r == CW'(MAX_RECORDS));
  assign count_after = full ? count_r : count_r + CW'(1);
  assign last_idx    = AW'(count_r - CW'(1));
  assign swap        = (rdata.key < held_r.key);
  assign more_passes = ((CW+1)'(i_r) + (CW+1)'(2)) < (CW+1)'(count_r);
  assign out_go      = (state_r == ST_OUT) && out_free;

  // Saturate keys that cannot fit the title buffer
  always_comb begin
    in_rec.id  = in_id;
    in_rec.key = ({3'b000, in_key} > KEY_TOP) ? KEY_TOP[KEY_W-1:0] : in_key;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept && in_last) begin
          state_nxt = (count_after == CW'(1)) ? ST_OUT_RD : ST_SORT_I;
        end
      end
      ST_SORT_I: state_nxt = ST_SORT_H;
      ST_SORT_H: state_nxt = ST_SORT_J;
      ST_SORT_J: begin
        if (j_r == last_idx) begin
          state_nxt = ST_SORT_W;
        end
      end
      ST_SORT_W: state_nxt = more_passes ? ST_SORT_I : ST_OUT_RD;
      ST_OUT_RD: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_go && (o_r == last_idx)) begin
          state_nxt = ST_LOAD;
        end
      end
      default:   state_nxt = ST_LOAD;
    endcase
  end

  // Memory port and handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = held_r;
    raddr     = '0;
    beat_load = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        we       = accept && !full;
        waddr    = AW'(count_r);
        wdata    = in_rec;
      end
      ST_SORT_I: raddr = i_r;
      ST_SORT_H: raddr = i_r + AW'(1);
      ST_SORT_J: begin
        raddr = j_r + AW'(1);
        we    = swap;
        waddr = j_r;
      end
      ST_SORT_W: begin
        we    = 1'b1;
        waddr = i_r;
      end
      ST_OUT_RD: raddr = o_r;
      ST_OUT: begin
        beat_load = out_free;
        raddr     = out_free ? o_r + AW'(1) : o_r;
      end
      default: ;
    endcase
  end

  assign beat.rec     = rdata;
  assign beat.last    = (o_r == last_idx);
  assign beat.dropped = overflow_r;

  // Datapath next values
  always_comb begin
    count_nxt    = count_r;
    overflow_nxt = overflow_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    o_nxt        = o_r;
    held_nxt     = held_r;
    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          count_nxt    = count_after;
          overflow_nxt = overflow_r || full;
          i_nxt        = '0;
          o_nxt        = '0;
        end
      end
      ST_SORT_H: begin
        held_nxt = rdata;
        j_nxt    = i_r + AW'(1);
      end
      ST_SORT_J: begin
        if (swap) begin
          held_nxt = rdata;
        end
        j_nxt = j_r + AW'(1);
      end
      ST_SORT_W: i_nxt = i_r + AW'(1);
      ST_OUT: begin
        if (out_go) begin
          o_nxt = o_r + AW'(1);
          if (o_r == last_idx) begin
            count_nxt    = '0;
            overflow_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      count_r    <= '0;
      overflow_r <= 1'b0;
      i_r        <= '0;
      j_r        <= '0;
      o_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      overflow_r <= overflow_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      o_r        <= o_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

// ----- hdl/record_exchange_sort_by_key.sv -----
// Record exchange sort by key. Input beats are accepted while loading; after the
// beat marked last, the records are sorted with one compare per cycle through
// the store's single read port; the first result is then read from the store into
// the output register, and one result per cycle follows while out_tready is high.
// Reset: synchronous, active low; clears the sequencer, count and drop flag.
// The record store is not cleared: only entries written in a run are read.
module record_exchange_sort_by_key #(
  parameter int MAX_RECORDS    = rexs_pkg::MAX_RECORDS_DEF,
  parameter int TITLE_CAPACITY = rexs_pkg::TITLE_CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input beats: one record each; tlast closes the run and starts the sort (skipped for a single record)
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rexs_pkg::TDATA_W-1:0]  in_tdata,  // [5:0] title_length, [21:6] record_id
  input  logic                          in_tlast,  // last_record
  // Result beats in ascending key order
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rexs_pkg::TDATA_W-1:0]  out_tdata, // [15:0] sorted_id, [21:16] sorted_length
  output logic                          out_tlast, // end_of_run
  output logic                          out_tuser  // records_dropped
);
  import rexs_pkg::*;

  logic  out_valid_r;
  beat_t out_beat_r;
  logic  out_free;
  logic  beat_load;
  beat_t beat;

  // Output register frees the sequencer as soon as the consumer takes a beat
  assign out_free = !out_valid_r || out_tready;

  rexs_ctrl #(
    .MAX_RECORDS    (MAX_RECORDS),
    .TITLE_CAPACITY (TITLE_CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_key    (in_tdata[KEY_W-1:0]),
    .in_id     (in_tdata[KEY_W+ID_W-1:KEY_W]),
    .in_last   (in_tlast),
    .out_free  (out_free),
    .beat_load (beat_load),
    .beat      (beat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (beat_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_load) begin
      out_beat_r <= beat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W-KEY_W-ID_W){1'b0}}, out_beat_r.rec.key, out_beat_r.rec.id};
  assign out_tlast  = out_beat_r.last;
  assign out_tuser  = out_beat_r.dropped;

endmodule
